// File: sv/tct_pkg.sv
// shared types and constants for the tcp connection table
// used by tct_cell, tcp_connection_table and tct_checker; no dependencies
`default_nettype none

package tct_pkg;

   localparam int unsigned TableDepth = 16;
   localparam int unsigned CntWidth   = $clog2(TableDepth);

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_DELETE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LAUNCH,
      S_SCAN,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [15:0] relay_port;
      logic [15:0] client_port;
      logic [31:0] client_addr;
   } data_type;

   typedef struct packed {
      logic     valid;
      data_type data;
   } entry_type;

   // search key broadcast to every cell
   typedef struct packed {
      logic     client_mode;
      data_type data;
   } key_type;

   // search wave handed from cell to cell
   typedef struct packed {
      logic     run;
      logic     found;
      data_type data;
   } wave_type;

   // table update commands
   typedef struct packed {
      logic shift_back;
      logic close_gap;
   } ctl_type;

endpackage

`default_nettype wire

// File: sv/tct_cell.sv
// one cell of the connection table: holds one entry, compares it with the key
// and passes the search wave to its neighbour; depends on tct_pkg
`default_nettype none

module tct_cell
   import tct_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire key_type    key,
   input  wire ctl_type    ctl,
   input  wire entry_type  prev_entry,
   input  wire entry_type  next_entry,
   input  wire wave_type   wave_in,
   output entry_type  entry,
   output wave_type   wave_out
);

   logic      valid_ff, valid_in;
   data_type  data_ff, data_in;
   logic      kill_ff, kill_in;
   wave_type  wave_ff, wave_in_next;
   logic      match;

   always_comb begin
      if (key.client_mode) begin
         match = valid_ff && (data_ff.client_addr == key.data.client_addr)
                 && (data_ff.client_port == key.data.client_port);
      end else begin
         match = valid_ff && (data_ff.relay_port == key.data.relay_port);
      end
   end

   // the first match on the way down wins; later cells pass it along
   always_comb begin
      wave_in_next.run   = wave_in.run;
      wave_in_next.found = wave_in.run && (wave_in.found || match);
      if (wave_in.found) begin
         wave_in_next.data = wave_in.data;
      end else if (match) begin
         wave_in_next.data = data_ff;
      end else begin
         wave_in_next.data = '0;
      end
   end

   // kill marks the matched cell and every cell behind it
   assign kill_in = wave_in.run ? (wave_in.found || match) : kill_ff;

   always_comb begin
      priority if (ctl.shift_back) begin
         valid_in = prev_entry.valid;
         data_in  = prev_entry.data;
      end else if (ctl.close_gap && kill_ff) begin
         valid_in = next_entry.valid;
         data_in  = next_entry.data;
      end else begin
         valid_in = valid_ff;
         data_in  = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         kill_ff  <= 1'b0;
         wave_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         kill_ff  <= kill_in;
         wave_ff  <= wave_in_next;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign entry.valid = valid_ff;
   assign entry.data  = data_ff;
   assign wave_out    = wave_ff;

endmodule

`default_nettype wire

// File: sv/tcp_connection_table.sv
// An item is worked on in steps: the sequencer launches the search, the search
// wave then walks the row of cells one cell per cycle (newest entry first), and
// last the result is registered and the table updated. One item is worked on at
// a time; the next is accepted as soon as the previous result is registered,
// even while that result still waits on the response port.
// The table is empty after reset with no clearing pass.
// top level; instantiates tct_cell, depends on tct_pkg
`default_nettype none

module tcp_connection_table
   import tct_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [1:0]  req_op,
   input  wire  [15:0] req_relay_port,
   input  wire  [15:0] req_client_port,
   input  wire  [31:0] req_client_addr,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_hit_relay_port,
   output logic [15:0] rsp_hit_client_port,
   output logic [31:0] rsp_hit_client_addr
);

   state_type            state_ff, state_in;
   logic [CntWidth-1:0]  cnt_ff, cnt_in;
   op_type               op_ff;
   key_type              key_ff;
   wave_type             hit_ff;
   logic                 rsp_valid_ff;
   status_type           status_ff, status_in;
   data_type             rsp_data_ff, rsp_data_in;

   logic       accept, out_free, finish, scan_last, full;
   wave_type   launch_wave;
   ctl_type    ctl;
   entry_type  entry_w [TableDepth];
   wave_type   wave_w  [TableDepth];
   entry_type  head_entry, tail_entry;

   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign scan_last = (state_ff == S_SCAN) && (cnt_ff == CntWidth'(TableDepth - 1));
   assign full      = entry_w[TableDepth-1].valid;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (accept) state_in = S_LAUNCH;
         S_LAUNCH: state_in = S_SCAN;
         S_SCAN:   if (scan_last) state_in = S_DONE;
         S_DONE:   if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready         = (state_ff == S_IDLE);
      finish            = (state_ff == S_DONE) && out_free;
      launch_wave.run   = (state_ff == S_LAUNCH);
      launch_wave.found = 1'b0;
      launch_wave.data  = '0;
      cnt_in            = (state_ff == S_SCAN) ? cnt_ff + 1'b1 : '0;
   end

   always_comb begin
      status_in   = ST_MISS;
      rsp_data_in = '0;
      unique case (op_ff)
         OP_INSERT: status_in = full ? ST_FULL : ST_OK;
         OP_LOOKUP, OP_DELETE: begin
            if (hit_ff.found) begin
               status_in   = ST_OK;
               rsp_data_in = hit_ff.data;
            end
         end
         default: status_in = ST_MISS;
      endcase
   end

   assign ctl.shift_back = finish && (op_ff == OP_INSERT) && !full;
   assign ctl.close_gap  = finish && (op_ff == OP_DELETE) && hit_ff.found;

   assign head_entry.valid = 1'b1;
   assign head_entry.data  = key_ff.data;
   assign tail_entry       = '0;

   for (genvar k = 0; k < TableDepth; k++) begin : g_cell
      tct_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .key        (key_ff),
         .ctl        (ctl),
         .prev_entry ((k == 0) ? head_entry : entry_w[(k == 0) ? 0 : k - 1]),
         .next_entry ((k == TableDepth - 1) ? tail_entry
                      : entry_w[(k == TableDepth - 1) ? k : k + 1]),
         .wave_in    ((k == 0) ? launch_wave : wave_w[(k == 0) ? 0 : k - 1]),
         .entry      (entry_w[k]),
         .wave_out   (wave_w[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff                   <= op_type'(req_op);
         key_ff.client_mode      <= (req_op == OP_LOOKUP) && (req_relay_port == 16'd0);
         key_ff.data.relay_port  <= req_relay_port;
         key_ff.data.client_port <= req_client_port;
         key_ff.data.client_addr <= req_client_addr;
      end
      if (scan_last) begin
         hit_ff <= wave_w[TableDepth-1];
      end
      if (finish) begin
         status_ff   <= status_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_hit_relay_port  = rsp_data_ff.relay_port;
   assign rsp_hit_client_port = rsp_data_ff.client_port;
   assign rsp_hit_client_addr = rsp_data_ff.client_addr;

endmodule

`default_nettype wire

// File: sv/tct_checker.sv
// port-level checks for tcp_connection_table, bound to the top level
// depends on tct_pkg
`default_nettype none

module tct_checker
   import tct_pkg::*;
(
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_ready,
   input wire [1:0]  req_op,
   input wire [15:0] req_relay_port,
   input wire [15:0] req_client_port,
   input wire [31:0] req_client_addr,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [1:0]  rsp_status,
   input wire [15:0] rsp_hit_relay_port,
   input wire [15:0] rsp_hit_client_port,
   input wire [31:0] rsp_hit_client_addr
);

   // a stalled result stays on the port
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_hit_relay_port) && $stable(rsp_hit_client_port)
         && $stable(rsp_hit_client_addr))
      else $error("result changed while stalled");

   // only one item in flight
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while another is in flight");

   // a result appears only at the end of an item's work
   a_rsp_after_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result without an item in flight");

   // misses and full reports carry no entry
   a_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_hit_relay_port == 16'd0)
         && (rsp_hit_client_port == 16'd0) && (rsp_hit_client_addr == 32'd0))
      else $error("hit fields set on a failed item");

endmodule

bind tcp_connection_table tct_checker u_tct_checker (.*);

`default_nettype wire
